/* rtl/array_table_insert_delete_search_macros.svh */
// Assertion macros used by the table back end.
`ifndef ARRAY_TABLE_INSERT_DELETE_SEARCH_MACROS_SVH
`define ARRAY_TABLE_INSERT_DELETE_SEARCH_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ATIDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ATIDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/atids_pkg.sv */
// Shared types and constants for the table RTL.
package atids_pkg;

  localparam int POS_W      = 4;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 3;
  localparam int IDX_OUT_W  = 4;
  localparam int FILL_W     = 5;
  localparam int CAP_W      = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 88;

  // Operation codes, in the order of the request's action field.
  typedef enum logic [1:0] {
    OP_INSERT,
    OP_DELETE,
    OP_SEARCH,
    OP_MINMAX
  } op_t;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    op_t                op;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [IDX_OUT_W-1:0] found_index;
    logic [VALUE_W-1:0]   min_value;
    logic [IDX_OUT_W-1:0] min_index;
    logic [VALUE_W-1:0]   max_value;
    logic [IDX_OUT_W-1:0] max_index;
    logic [FILL_W-1:0]    fill_count;
  } res_t;

endpackage

/* rtl/array_table_insert_delete_search.sv */
// Top level of the signed-word table: front decoder/queue and back execution unit.
//
// Usage:
//  - Requests enter on in_* (tvalid/tready). in_tuser carries the action
//    (insert, delete, search, min/max); in_tdata carries position and value.
//  - Each request returns exactly one result on out_*: out_tuser is the
//    status, out_tdata packs search index, min/max words and indexes, and the
//    fill count after the operation.
//  - cfg_wr_en/cfg_wr_data write the capacity (clamped to 1..DEPTH); write it
//    only while no request is in flight. Shrinking drops entries past it.
// Timing:
//  - Insert/delete: queued, then result registered; one per cycle sustained
//    while out_tready is high, the back unit updates the whole cell chain at once.
//  - Search, min/max: no new request is taken until the scan ends; the
//    chain rotates past a single compare unit one entry per cycle.
//  - A two-deep request queue lets the front keep accepting while the back
//    works or the result register waits on out_tready; a stalled receiver
//    holds the result and the back pauses, nothing is dropped.
// Reset: table cleared to zero, fill count 0, capacity min(16, DEPTH).
module array_table_insert_delete_search import atids_pkg::*; #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [1:0]            in_tuser,   // action
  input  logic [IN_DATA_W-1:0]  in_tdata,   // position[3:0], value[35:4], zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [STATUS_W-1:0]   out_tuser,  // status
  output logic [OUT_DATA_W-1:0] out_tdata,  // found_index[3:0], min_value[35:4],
                                            // min_index[39:36], max_value[71:40],
                                            // max_index[75:72], fill_count[80:76]
  input  logic                  cfg_wr_en,
  input  logic [CAP_W-1:0]      cfg_wr_data // capacity
);

  logic req_valid;
  logic req_ready;
  req_t req;
  res_t res;

  atids_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req)
  );

  atids_back #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .out_tready  (out_tready),
    .out_valid   (out_tvalid),
    .res         (res)
  );

  // pack result fields, lowest first, zero pad to whole bytes
  assign out_tuser = res.status;
  assign out_tdata = {7'd0, res.fill_count, res.max_index, res.max_value,
                      res.min_index, res.min_value, res.found_index};

endmodule

/* rtl/atids_front.sv */
// Front end: accepts requests, decodes the operation and queues them.
module atids_front import atids_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [1:0]           in_tuser,
  input  logic [IN_DATA_W-1:0] in_tdata,
  output logic                 req_valid,
  input  logic                 req_ready,
  output req_t                 req
);

  req_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       push;
  logic       pop;
  req_t       dec;

  // action codes map one to one onto op_t
  always_comb begin
    dec.op    = op_t'(in_tuser);
    dec.pos   = in_tdata[POS_W-1:0];
    dec.value = in_tdata[POS_W+VALUE_W-1:POS_W];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign req_valid = (cnt_r != 2'd0);
  assign req       = q_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = req_valid && req_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

/* rtl/atids_back.sv */
// Back end: cell chain holding the table, operation sequencer and result register.
`include "array_table_insert_delete_search_macros.svh"

module atids_back import atids_pkg::*; #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  input  logic             out_tready,
  output logic             out_valid,
  output res_t             res
);

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CW      = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int CAP_RST = (DEPTH < 16) ? DEPTH : 16;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cap_r, cap_nxt;
  logic [CNT_W-1:0]     fill_r, fill_nxt;
  logic [IDX_W-1:0]     scan_r, scan_nxt;
  op_t                  op_r, op_nxt;
  logic [WORD_BITS-1:0] key_r, key_nxt;
  logic                 hit_r, hit_nxt;
  logic [IDX_W-1:0]     found_r, found_nxt;
  logic [WORD_BITS-1:0] minv_r, minv_nxt, maxv_r, maxv_nxt;
  logic [IDX_W-1:0]     mini_r, mini_nxt, maxi_r, maxi_nxt;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 res_r, res_nxt;

  logic [WORD_BITS-1:0] cell_r   [DEPTH];
  logic [WORD_BITS-1:0] cell_nxt [DEPTH];

  logic                 out_free;
  logic                 take;
  logic [WORD_BITS-1:0] key_in;
  logic [CW-1:0]        pos_x, fill_x, cap_x, cfg_x;
  logic [CNT_W-1:0]     cap_new, fill_cut;
  logic                 ins_ok, del_ok;
  logic [CW-1:0]        fill_ins;
  logic [WORD_BITS-1:0] head;
  logic                 in_cap, match;

  assign out_free  = !out_valid_r || out_tready;
  assign req_ready = (state_r == S_IDLE) && out_free;
  assign take      = req_valid && req_ready;
  assign out_valid = out_valid_r;
  assign res       = res_r;

  assign key_in = WORD_BITS'($signed(req.value));
  assign pos_x  = CW'(req.pos);
  assign fill_x = CW'(fill_r);
  assign cap_x  = CW'(cap_r);
  assign cfg_x  = CW'(cfg_wr_data);

  // capacity clamps to 1..DEPTH; fill is cut back to it
  always_comb begin
    if (cfg_x == '0) begin
      cap_new = CNT_W'(1);
    end else if (cfg_x > CW'(DEPTH)) begin
      cap_new = CNT_W'(DEPTH);
    end else begin
      cap_new = CNT_W'(cfg_x);
    end
    fill_cut = (fill_r > cap_new) ? cap_new : fill_r;
  end

  assign ins_ok   = (pos_x < cap_x) && (fill_x < cap_x);
  assign del_ok   = (fill_x != '0) && (pos_x < fill_x);
  assign fill_ins = (pos_x <= fill_x) ? CW'(fill_x + 1'b1) : CW'(pos_x + 1'b1);

  // scan reads the chain head; the ring rotates once per step
  assign head   = cell_r[0];
  assign in_cap = CW'(scan_r) < cap_x;
  assign match  = in_cap && (head == key_r);

  // Cell chain: each cell sees only its two neighbors.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam logic [CW-1:0] GI = CW'(g);
    logic [WORD_BITS-1:0] left_w, right_w, rot_w;

    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_r[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
      assign rot_w   = cell_r[0];
    end else begin : g_mid_r
      assign right_w = cell_r[g+1];
      assign rot_w   = cell_r[g+1];
    end

    always_comb begin
      cell_nxt[g] = cell_r[g];
      if (cfg_wr_en) begin
        if (GI >= CW'(fill_cut)) begin
          cell_nxt[g] = '0;
        end
      end else if (state_r == S_SCAN) begin
        cell_nxt[g] = rot_w;
      end else if (take && req.op == OP_INSERT && ins_ok) begin
        if (GI == pos_x) begin
          cell_nxt[g] = key_in;
        end else if (GI > pos_x && GI <= fill_x) begin
          cell_nxt[g] = left_w;
        end
      end else if (take && req.op == OP_DELETE && del_ok) begin
        // cell at fill is zero, so the old last entry clears itself
        if (GI >= pos_x && GI < fill_x) begin
          cell_nxt[g] = right_w;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cell_r[g] <= '0;
      end else begin
        cell_r[g] <= cell_nxt[g];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cap_nxt       = cap_r;
    fill_nxt      = fill_r;
    scan_nxt      = scan_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    hit_nxt       = hit_r;
    found_nxt     = found_r;
    minv_nxt      = minv_r;
    maxv_nxt      = maxv_r;
    mini_nxt      = mini_r;
    maxi_nxt      = maxi_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (cfg_wr_en) begin
      cap_nxt  = cap_new;
      fill_nxt = fill_cut;
    end

    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          res_nxt            = '0;
          res_nxt.status     = ST_OK;
          res_nxt.fill_count = FILL_W'(fill_r);
          unique case (req.op) inside
            OP_INSERT: begin
              out_valid_nxt = 1'b1;
              if (!ins_ok) begin
                res_nxt.status = ST_OVERFLOW;
              end else begin
                fill_nxt           = CNT_W'(fill_ins);
                res_nxt.fill_count = FILL_W'(fill_ins);
              end
            end
            OP_DELETE: begin
              out_valid_nxt = 1'b1;
              if (fill_x == '0) begin
                res_nxt.status = ST_UNDERFLOW;
              end else if (!del_ok) begin
                res_nxt.status = ST_BAD_INDEX;
              end else begin
                fill_nxt           = fill_r - 1'b1;
                res_nxt.fill_count = FILL_W'(fill_r - 1'b1);
              end
            end
            OP_SEARCH, OP_MINMAX: begin
              op_nxt    = req.op;
              key_nxt   = key_in;
              scan_nxt  = '0;
              hit_nxt   = 1'b0;
              found_nxt = '0;
              state_nxt = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (match) begin
          hit_nxt   = 1'b1;
          found_nxt = scan_r;
        end
        if (scan_r == '0) begin
          minv_nxt = head;
          maxv_nxt = head;
          mini_nxt = '0;
          maxi_nxt = '0;
        end else if (in_cap) begin
          if ($signed(head) < $signed(minv_r)) begin
            minv_nxt = head;
            mini_nxt = scan_r;
          end
          if ($signed(head) > $signed(maxv_r)) begin
            maxv_nxt = head;
            maxi_nxt = scan_r;
          end
        end
        if (scan_r == LAST) begin
          state_nxt          = S_IDLE;
          out_valid_nxt      = 1'b1;
          res_nxt            = '0;
          res_nxt.fill_count = FILL_W'(fill_r);
          if (op_r == OP_SEARCH) begin
            res_nxt.status      = hit_nxt ? ST_OK : ST_NOT_FOUND;
            res_nxt.found_index = IDX_OUT_W'(found_nxt);
          end else begin
            res_nxt.status    = ST_OK;
            res_nxt.min_value = VALUE_W'(minv_nxt);
            res_nxt.min_index = IDX_OUT_W'(mini_nxt);
            res_nxt.max_value = VALUE_W'(maxv_nxt);
            res_nxt.max_index = IDX_OUT_W'(maxi_nxt);
          end
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CNT_W'(CAP_RST);
      fill_r      <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
      res_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      fill_r      <= fill_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
      res_r       <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    hit_r   <= hit_nxt;
    found_r <= found_nxt;
    minv_r  <= minv_nxt;
    maxv_r  <= maxv_nxt;
    mini_r  <= mini_nxt;
    maxi_r  <= maxi_nxt;
  end

  `ATIDS_ASSERT_IMP(a_fill_le_cap, clk, rst_n, 1'b1, fill_r <= cap_r, "fill above capacity")
  `ATIDS_ASSERT_NXT(a_scan_done, clk, rst_n, (state_r == S_SCAN) && (scan_r == LAST), out_valid_r && (state_r == S_IDLE), "scan end gave no result")
  `ATIDS_ASSERT_IMP(a_tail_zero, clk, rst_n, (state_r == S_IDLE) && (fill_x < CW'(DEPTH)), cell_r[DEPTH-1] == '0, "unused tail entry not zero")

endmodule
